// ----- rtl/tcsm_pkg.sv -----
// Shared types and constants for the ternary cube set merge block.
package tcsm_pkg;

	localparam int CUBE_W = 32;

	localparam logic [1:0] POS_FIRST  = 2'd0;
	localparam logic [1:0] POS_SECOND = 2'd1;
	localparam logic [1:0] POS_DC     = 2'd2;

	typedef struct packed {
		logic [CUBE_W-1:0] cube_in;
		logic              last_in;
	} item_t;

	typedef struct packed {
		logic [CUBE_W-1:0] cube_out;
		logic              last_out;
		logic              overflow;
	} result_t;

	typedef struct packed {
		logic [CUBE_W-1:0] key_a;
		logic [CUBE_W-1:0] key_b;
	} cmp_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_DUP,
		ST_MRG,
		ST_OUT
	} state_t;

endpackage

// ----- rtl/ternary_cube_set_merge.sv -----
// Top level of the ternary cube set merge block: sequencer, cell row and result register.
// Usage:
//   Input channel item/item_valid/item_stall carries one cube per transfer; the cube
//   with last_in set closes the set. Cubes beyond SET_SIZE are dropped and the
//   overflow bit of every result of that set is raised.
//   Output channel res/res_valid/res_stall carries the survivors in store order,
//   last_out marking the final one.
// Sequence:
//   Loading accepts a cube on each transfer. After the last cube the sequencer runs
//   reduction rounds over the cell row: a duplicate pass steps over each entry,
//   a merge pass over each (entry, position) pair, and each change restarts
//   from the duplicate pass, with up to N rounds for N held cubes. Results then
//   leave at one per cycle while res_stall is low.
// Reset:
//   arst_n clears the count, the overflow flag, the sequencer and the output valid.
// Stall:
//   item_stall is high while the set is reduced or emitted. A stalled result
//   holds in the output register and emission pauses.
module ternary_cube_set_merge #(
	parameter int POSITIONS = 16,
	parameter int SET_SIZE  = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  tcsm_pkg::item_t   item,
	output logic              res_valid,
	input  logic              res_stall,
	output tcsm_pkg::result_t res
);
	import tcsm_pkg::*;

	localparam int CW = $clog2(SET_SIZE + 1);
	localparam int IW = $clog2(SET_SIZE);
	localparam int PW = $clog2(POSITIONS + 1);
	localparam logic [CUBE_W-1:0] POS_MASK = (POSITIONS >= 16) ? {CUBE_W{1'b1}} :
		CUBE_W'((64'd1 << (2 * POSITIONS)) - 64'd1);

	state_t         state_q, state_d;
	logic [CW-1:0]  count_q, count_d;
	logic [CW-1:0]  i_q, i_d;
	logic [PW-1:0]  p_q, p_d;
	logic           ovf_q, ovf_d;
	logic           out_valid_q, out_valid_d;
	result_t        out_q, out_d;

	logic [SET_SIZE-1:0]   wr_en, en, hit, hit_a;
	logic [SET_SIZE:0]     claim;
	logic [CUBE_W-1:0]     wr_data [SET_SIZE];
	logic [CUBE_W-1:0]     cube [SET_SIZE];
	cmp_t                  cmp;

	logic [CUBE_W-1:0] cur, last_cube, query, new_i, pmask;
	logic [1:0]        v;
	logic [IW-1:0]     hit_idx;
	logic              any_hit, kind_a, slot_free;
	logic [IW-1:0]     cnt_m1;

	genvar g;
	generate
		for (g = 0; g < SET_SIZE; g++) begin : g_cell
			tcsm_cell u_cell (
				.clk      (clk),
				.wr_en    (wr_en[g]),
				.wr_data  (wr_data[g]),
				.en       (en[g]),
				.cmp      (cmp),
				.claim_in (claim[g]),
				.claim_out(claim[g+1]),
				.hit      (hit[g]),
				.hit_a    (hit_a[g]),
				.cube     (cube[g])
			);
		end
	endgenerate

	assign claim[0] = 1'b0;
	assign cnt_m1   = IW'(count_q - CW'(1));
	assign cur      = cube[i_q[IW-1:0]];
	assign last_cube = cube[cnt_m1];
	assign pmask    = 32'd3 << {p_q, 1'b0};
	assign v        = 2'(cur >> {p_q, 1'b0});
	assign query    = (cur & ~pmask) |
		(CUBE_W'((v == POS_FIRST) ? POS_SECOND : POS_FIRST) << {p_q, 1'b0});
	assign new_i    = (cur & ~pmask) | (CUBE_W'(POS_DC) << {p_q, 1'b0});
	assign slot_free = !out_valid_q || !res_stall;

	always_comb begin
		cmp.key_a = (state_q == ST_MRG) ? query : cur;
		cmp.key_b = cur;
		for (int j = 0; j < SET_SIZE; j++) begin
			en[j] = (CW'(j) < count_q) &&
				(((state_q == ST_DUP) && (CW'(j) > i_q)) ||
				 ((state_q == ST_MRG) && (CW'(j) != i_q) && (v != POS_DC)));
		end
		any_hit = |hit;
		kind_a  = (state_q == ST_MRG) && (|hit_a);
		hit_idx = '0;
		for (int j = 0; j < SET_SIZE; j++) begin
			if (hit[j]) begin
				hit_idx = hit_idx | IW'(j);
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		i_d         = i_q;
		p_d         = p_q;
		ovf_d       = ovf_q;
		out_valid_d = out_valid_q && res_stall;
		out_d       = out_q;
		item_stall  = (state_q != ST_LOAD);
		for (int j = 0; j < SET_SIZE; j++) begin
			wr_en[j]   = 1'b0;
			wr_data[j] = last_cube;
		end
		case (state_q)
			ST_LOAD: begin
				if (item_valid) begin
					if (count_q < CW'(SET_SIZE)) begin
						wr_en[count_q[IW-1:0]]   = 1'b1;
						wr_data[count_q[IW-1:0]] = item.cube_in & POS_MASK;
						count_d = count_q + CW'(1);
					end else begin
						ovf_d = 1'b1;
					end
					if (item.last_in) begin
						state_d = ST_DUP;
						i_d     = '0;
					end
				end
			end
			ST_DUP: begin
				if (any_hit) begin
					wr_en[hit_idx] = 1'b1;
					count_d = count_q - CW'(1);
					i_d     = '0;
				end else if (i_q + CW'(1) >= count_q) begin
					state_d = ST_MRG;
					i_d     = '0;
					p_d     = '0;
				end else begin
					i_d = i_q + CW'(1);
				end
			end
			ST_MRG: begin
				if (any_hit) begin
					if (kind_a) begin
						wr_en[i_q[IW-1:0]]   = 1'b1;
						wr_data[i_q[IW-1:0]] = new_i;
					end
					wr_en[hit_idx]   = 1'b1;
					wr_data[hit_idx] = (kind_a && (IW'(i_q) == cnt_m1)) ? new_i : last_cube;
					count_d = count_q - CW'(1);
					state_d = ST_DUP;
					i_d     = '0;
					p_d     = '0;
				end else if (p_q == PW'(POSITIONS - 1)) begin
					p_d = '0;
					if (i_q + CW'(1) >= count_q) begin
						state_d = ST_OUT;
						i_d     = '0;
					end else begin
						i_d = i_q + CW'(1);
					end
				end else begin
					p_d = p_q + PW'(1);
				end
			end
			ST_OUT: begin
				if (slot_free) begin
					out_valid_d     = 1'b1;
					out_d.cube_out  = cur;
					out_d.last_out  = (i_q + CW'(1) == count_q);
					out_d.overflow  = ovf_q;
					i_d = i_q + CW'(1);
					if (i_q + CW'(1) == count_q) begin
						state_d = ST_LOAD;
						count_d = '0;
						ovf_d   = 1'b0;
						i_d     = '0;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			i_q         <= '0;
			p_q         <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			i_q         <= i_d;
			p_q         <= p_d;
			ovf_q       <= ovf_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		out_q <= out_d;
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

// ----- rtl/tcsm_cell.sv -----
// One store cell: holds a cube, compares it with the broadcast keys, claims the first hit.
module tcsm_cell (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [tcsm_pkg::CUBE_W-1:0] wr_data,
	input  logic                      en,
	input  tcsm_pkg::cmp_t            cmp,
	input  logic                      claim_in,
	output logic                      claim_out,
	output logic                      hit,
	output logic                      hit_a,
	output logic [tcsm_pkg::CUBE_W-1:0] cube
);
	import tcsm_pkg::*;

	logic [CUBE_W-1:0] cube_q;
	logic              match;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			cube_q <= wr_data;
		end
	end

	assign match     = en && ((cube_q == cmp.key_a) || (cube_q == cmp.key_b));
	assign hit       = match && !claim_in;
	assign hit_a     = hit && (cube_q == cmp.key_a);
	assign claim_out = claim_in || match;
	assign cube      = cube_q;

endmodule
